FILE: hw/rtl/asfd_pkg.sv
// Constants, types and frame layout shared by the air sensor frame decoder.
`default_nettype none

package asfd_pkg;

	localparam int unsigned FRAME_LEN   = 17;
	localparam int unsigned STORE_DEPTH = FRAME_LEN - 1;
	localparam int unsigned CNT_W       = $clog2(FRAME_LEN);
	localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);

	localparam logic [7:0]  HDR_BYTE      = 8'h3C;
	localparam logic [7:0]  SECOND_BYTE   = 8'h02;
	localparam logic [15:0] TIMEOUT_RESET = 16'd500;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_ID  = 2'd1,
		ST_BAD_SUM = 2'd2
	} status_t;

	typedef struct packed {
		logic                        last;
		logic [7:0]                  sum;
		logic [FRAME_LEN-1:0][7:0]   data;
	} frame_t;

endpackage

`default_nettype wire

FILE: hw/rtl/asfd_if.sv
// Handshake channels for request beats and decoded result beats.
`default_nettype none

interface asfd_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface asfd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] co2_ppm;
	logic [15:0] hcho_level;
	logic [15:0] tvoc_level;
	logic [15:0] pm25_level;
	logic [15:0] pm10_level;
	logic signed [14:0] temp_centi;
	logic [14:0] humidity_centi;

	modport source (
		output valid, output status, output co2_ppm, output hcho_level,
		output tvoc_level, output pm25_level, output pm10_level,
		output temp_centi, output humidity_centi, input ready
	);
	modport sink (
		input valid, input status, input co2_ppm, input hcho_level,
		input tvoc_level, input pm25_level, input pm10_level,
		input temp_centi, input humidity_centi, output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/asfd_collector.sv
// Input register, header hunt, frame capture, checksum and idle timeout.
`default_nettype none

module asfd_collector
	import asfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	asfd_req_if.sink         req,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        adv,
	output frame_t           frm
);

	logic                   valid_s1;
	logic                   req_type_s1;
	logic [7:0]             rx_byte_s1;
	logic                   consume;
	logic [15:0]            timeout_q;
	logic                   framing_q;
	logic [CNT_W-1:0]       count_q;
	logic [7:0]             sum_q;
	logic [15:0]            idle_q;
	logic [15:0]            idle_inc;
	logic [STORE_DEPTH-1:0][7:0] store_q;

	assign req.ready = !valid_s1 || adv;
	assign consume   = valid_s1 && adv;
	assign idle_inc  = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready) begin
			req_type_s1 <= req.req_type;
			rx_byte_s1  <= req.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framing_q <= 1'b0;
			count_q   <= '0;
			sum_q     <= '0;
			idle_q    <= '0;
		end else if (consume) begin
			if (req_type_s1 == REQ_TICK) begin
				if (framing_q) begin
					if (idle_inc > timeout_q) begin
						framing_q <= 1'b0;
						count_q   <= '0;
						sum_q     <= '0;
						idle_q    <= '0;
					end else begin
						idle_q <= idle_inc;
					end
				end
			end else if (!framing_q) begin
				if (rx_byte_s1 == HDR_BYTE) begin
					framing_q <= 1'b1;
					count_q   <= CNT_W'(1);
					sum_q     <= rx_byte_s1;
					idle_q    <= '0;
				end
			end else if (count_q == LAST_IDX) begin
				framing_q <= 1'b0;
				count_q   <= '0;
				sum_q     <= '0;
				idle_q    <= '0;
			end else begin
				count_q <= count_q + CNT_W'(1);
				sum_q   <= sum_q + rx_byte_s1;
				idle_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume && req_type_s1 == REQ_BYTE) begin
			if (!framing_q) begin
				store_q[0] <= rx_byte_s1;
			end else if (count_q != LAST_IDX) begin
				store_q[count_q[IDX_W-1:0]] <= rx_byte_s1;
			end
		end
	end

	always_comb begin
		frm.last = consume && req_type_s1 == REQ_BYTE && framing_q && count_q == LAST_IDX;
		frm.sum  = sum_q;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			frm.data[i] = store_q[i];
		end
		frm.data[FRAME_LEN-1] = rx_byte_s1;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/asfd_decoder.sv
// Frame check, reading decode and result register.
`default_nettype none

module asfd_decoder
	import asfd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire frame_t frm,
	output logic        adv,
	asfd_res_if.source  res
);

	logic        valid_q;
	status_t     status_q;
	status_t     status_c;
	logic [15:0] co2_q, hcho_q, tvoc_q, pm25_q, pm10_q;
	logic [14:0] temp_q, hum_q;
	logic [13:0] temp_mag;
	logic [14:0] temp_c;
	logic [14:0] hum_c;
	logic        ok;

	assign adv = !valid_q || res.ready;

	always_comb begin
		priority if (frm.data[1] != SECOND_BYTE) begin
			status_c = ST_BAD_ID;
		end else if (frm.sum != frm.data[FRAME_LEN-1]) begin
			status_c = ST_BAD_SUM;
		end else begin
			status_c = ST_OK;
		end
		ok       = status_c == ST_OK;
		temp_mag = 14'(frm.data[12][6:0] * 14'd100) + 14'(frm.data[13]);
		temp_c   = frm.data[12][7] ? 15'(-{1'b0, temp_mag}) : {1'b0, temp_mag};
		hum_c    = 15'(frm.data[14] * 15'd100) + 15'(frm.data[15]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= frm.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && frm.last) begin
			status_q <= status_c;
			co2_q    <= ok ? {frm.data[2], frm.data[3]} : '0;
			hcho_q   <= ok ? {frm.data[4], frm.data[5]} : '0;
			tvoc_q   <= ok ? {frm.data[6], frm.data[7]} : '0;
			pm25_q   <= ok ? {frm.data[8], frm.data[9]} : '0;
			pm10_q   <= ok ? {frm.data[10], frm.data[11]} : '0;
			temp_q   <= ok ? temp_c : '0;
			hum_q    <= ok ? hum_c : '0;
		end
	end

	assign res.valid          = valid_q;
	assign res.status         = status_q;
	assign res.co2_ppm        = co2_q;
	assign res.hcho_level     = hcho_q;
	assign res.tvoc_level     = tvoc_q;
	assign res.pm25_level     = pm25_q;
	assign res.pm10_level     = pm10_q;
	assign res.temp_centi     = $signed(temp_q);
	assign res.humidity_centi = hum_q;

endmodule

`default_nettype wire

FILE: hw/rtl/air_sensor_frame_decoder.sv
// Top level of the air sensor frame decoder.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, rx_byte
//   res      out  valid/ready   status, five readings, temp_centi, humidity_centi
//   cfg      in   cfg_we        cfg_wdata (timeout_ticks)
//
// One beat per cycle while a held result does not stall; the last frame byte passes
// the input register, then the result register, before the result is valid.
// Reset returns to header hunt with timeout_ticks at 500.
// A held result stalls the input register only while it waits to be taken.
`default_nettype none

module air_sensor_frame_decoder
	import asfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	asfd_req_if.sink         req,
	asfd_res_if.source       res,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	frame_t frm;
	logic   adv;

	asfd_collector u_collector (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.frm       (frm)
	);

	asfd_decoder u_decoder (
		.clk    (clk),
		.arst_n (arst_n),
		.frm    (frm),
		.adv    (adv),
		.res    (res)
	);

endmodule

`default_nettype wire

FILE: test/asfd_decode_check.sv
// Watches the request and result channels, decodes frames alongside the block and compares results.
`timescale 1ns / 1ps

module asfd_decode_check
	import asfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	asfd_req_if              req,
	asfd_res_if              res,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output int unsigned      pending,
	output int unsigned      mismatches,
	output int unsigned      frames_seen
);

	typedef struct packed {
		status_t            status;
		logic [15:0]        co2;
		logic [15:0]        hcho;
		logic [15:0]        tvoc;
		logic [15:0]        pm25;
		logic [15:0]        pm10;
		logic signed [14:0] temp;
		logic [14:0]        hum;
	} reading_t;

	reading_t    decoded_q[$];
	reading_t    want;
	logic        framing;
	logic [4:0]  fill_cnt;
	logic [7:0]  rx_store [FRAME_LEN];
	logic [7:0]  sum_acc;
	logic [15:0] quiet_ticks;
	logic [15:0] drop_after;
	int unsigned fail_tally = 0;
	int unsigned frames_tally = 0;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] exp_val);
		$display("%0t ns: %s got %h, wanted %h", $realtime, what, got, exp_val);
		fail_tally++;
	endtask

	task automatic restart_hunt();
		framing = 1'b0;
		fill_cnt = '0;
		sum_acc = '0;
		quiet_ticks = '0;
	endtask

	function automatic reading_t decode_frame();
		reading_t    r;
		logic [15:0] mag;
		r = '0;
		if (rx_store[1] != SECOND_BYTE) begin
			r.status = ST_BAD_ID;
		end else if (sum_acc != rx_store[LAST_IDX]) begin
			r.status = ST_BAD_SUM;
		end else begin
			r.status = ST_OK;
			r.co2  = {rx_store[2], rx_store[3]};
			r.hcho = {rx_store[4], rx_store[5]};
			r.tvoc = {rx_store[6], rx_store[7]};
			r.pm25 = {rx_store[8], rx_store[9]};
			r.pm10 = {rx_store[10], rx_store[11]};
			mag = 16'(rx_store[12][6:0]) * 16'd100 + 16'(rx_store[13]);
			r.temp = rx_store[12][7] ? 15'(-mag) : 15'(mag);
			r.hum = 15'(16'(rx_store[14]) * 16'd100 + 16'(rx_store[15]));
		end
		return r;
	endfunction

	task automatic take_beat(input logic kind, input logic [7:0] b);
		if (kind == REQ_TICK) begin
			if (framing) begin
				if (quiet_ticks != IDLE_MAX)
					quiet_ticks++;
				if (quiet_ticks > drop_after)
					restart_hunt();
			end
		end else if (!framing) begin
			if (b == HDR_BYTE) begin
				framing = 1'b1;
				rx_store[0] = b;
				fill_cnt = 5'd1;
				sum_acc = b;
				quiet_ticks = '0;
			end
		end else begin
			quiet_ticks = '0;
			rx_store[fill_cnt] = b;
			if (fill_cnt < LAST_IDX)
				sum_acc = sum_acc + b;
			fill_cnt++;
			if (fill_cnt == FRAME_LEN) begin
				decoded_q.push_back(decode_frame());
				restart_hunt();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_after = TIMEOUT_RESET;
			restart_hunt();
			decoded_q.delete();
		end else begin
			if (cfg_we)
				drop_after = cfg_wdata;
			if (req.valid && req.ready)
				take_beat(req.req_type, req.rx_byte);
			if (res.valid && res.ready) begin
				if (decoded_q.size() == 0) begin
					report_mismatch("result beat with no frame pending", 16'(res.status), 16'd0);
				end else begin
					want = decoded_q.pop_front();
					frames_tally++;
					if (res.status != want.status)
						report_mismatch("status", 16'(res.status), 16'(want.status));
					if (res.co2_ppm != want.co2)
						report_mismatch("co2_ppm", res.co2_ppm, want.co2);
					if (res.hcho_level != want.hcho)
						report_mismatch("hcho_level", res.hcho_level, want.hcho);
					if (res.tvoc_level != want.tvoc)
						report_mismatch("tvoc_level", res.tvoc_level, want.tvoc);
					if (res.pm25_level != want.pm25)
						report_mismatch("pm25_level", res.pm25_level, want.pm25);
					if (res.pm10_level != want.pm10)
						report_mismatch("pm10_level", res.pm10_level, want.pm10);
					if (res.temp_centi != want.temp)
						report_mismatch("temp_centi", 16'(res.temp_centi), 16'(want.temp));
					if (res.humidity_centi != want.hum)
						report_mismatch("humidity_centi", 16'(res.humidity_centi),
							16'(want.hum));
				end
			end
		end
		pending <= decoded_q.size();
		mismatches <= fail_tally;
		frames_seen <= frames_tally;
	end

endmodule

FILE: test/tb_top.sv
// Top of the frame decoder testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module tb_top;
	import asfd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	int unsigned pending_frames;
	int unsigned mismatch_total;
	int unsigned frames_done;

	int          src_idle;
	int          snk_idle;
	logic [15:0] cur_timeout;
	logic [7:0]  pkt_bytes [FRAME_LEN];
	int unsigned beats_sent = 0;
	int unsigned ignored_beats = 0;
	int unsigned cfg_writes = 0;

	asfd_req_if req_ch ();
	asfd_res_if res_ch ();

	air_sensor_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	asfd_decode_check check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.res         (res_ch),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.pending     (pending_frames),
		.mismatches  (mismatch_total),
		.frames_seen (frames_done)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("air_sensor_frame_decoder: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= snk_idle);
	end

	task automatic send_beat(input logic kind, input logic [7:0] b);
		while ($urandom_range(99) < src_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.rx_byte <= b;
		do @(posedge clk); while (!req_ch.ready);
		beats_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_beat(REQ_BYTE, b);
	endtask

	task automatic send_tick();
		send_beat(REQ_TICK, 8'($urandom));
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_tick();
	endtask

	task automatic fill_random();
		pkt_bytes[1] = SECOND_BYTE;
		for (int i = 2; i < FRAME_LEN - 1; i++)
			pkt_bytes[i] = 8'($urandom);
	endtask

	task automatic fill_const(input logic [7:0] v);
		pkt_bytes[1] = SECOND_BYTE;
		for (int i = 2; i < FRAME_LEN - 1; i++)
			pkt_bytes[i] = v;
	endtask

	task automatic seal_frame();
		logic [7:0] s;
		pkt_bytes[0] = HDR_BYTE;
		s = '0;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			s = s + pkt_bytes[i];
		pkt_bytes[LAST_IDX] = s;
	endtask

	task automatic send_span(input int first, input int last, input int cap);
		for (int i = first; i <= last; i++) begin
			if (i != 0 && cap != 0 && $urandom_range(99) < 15)
				send_ticks($urandom_range(cap, 1));
			send_byte(pkt_bytes[i]);
		end
	endtask

	task automatic send_frame(input int cap);
		send_span(0, FRAME_LEN - 1, cap);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_frames != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_timeout = v;
		cfg_writes++;
	endtask

	initial begin
		int          pick;
		int          cap;
		int          cut;
		int          n;
		int unsigned mark;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_BYTE;
		req_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		src_idle = 0;
		snk_idle = 0;
		cur_timeout = TIMEOUT_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hunting: ticks and stray bytes
		send_tick();
		send_tick();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SECOND_BYTE);
		send_byte(HDR_BYTE ^ 8'h01);

		fill_const(8'h00);
		seal_frame();
		send_frame(0);
		fill_const(8'hFF);
		seal_frame();
		send_frame(0);
		fill_random();
		pkt_bytes[12] = 8'h7F;
		pkt_bytes[13] = 8'hFF;
		seal_frame();
		send_frame(0);
		fill_random();
		pkt_bytes[12] = 8'h80;
		pkt_bytes[13] = 8'h00;
		seal_frame();
		send_frame(0);

		// header value carried as data
		fill_random();
		pkt_bytes[2] = HDR_BYTE;
		pkt_bytes[9] = HDR_BYTE;
		pkt_bytes[15] = HDR_BYTE;
		seal_frame();
		send_frame(0);

		fill_random();
		pkt_bytes[1] = 8'h03;
		seal_frame();
		send_frame(0);
		fill_random();
		pkt_bytes[1] = HDR_BYTE;
		seal_frame();
		pkt_bytes[LAST_IDX] ^= 8'h5A;
		send_frame(0);
		fill_random();
		seal_frame();
		pkt_bytes[LAST_IDX] += 8'd1;
		send_frame(0);

		// reset timeout: one tick past the limit drops the frame
		fill_random();
		seal_frame();
		send_span(0, 4, 0);
		send_ticks(TIMEOUT_RESET + 1);
		send_frame(0);

		write_timeout(16'd0);
		fill_random();
		seal_frame();
		send_span(0, 3, 0);
		send_tick();
		send_frame(0);

		// widest limit keeps the frame
		write_timeout(16'hFFFF);
		fill_random();
		seal_frame();
		send_span(0, 9, 0);
		send_ticks(120);
		send_span(10, FRAME_LEN - 1, 0);

		write_timeout(16'd1);
		fill_random();
		seal_frame();
		send_span(0, 5, 0);
		send_ticks(1);
		send_span(6, FRAME_LEN - 1, 0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle = 0;
					snk_idle = 0;
					write_timeout(16'($urandom_range(6, 1)));
				end
				1: begin
					src_idle = 49;
					snk_idle = 0;
					write_timeout(16'd0);
				end
				2: begin
					src_idle = 0;
					snk_idle = 49;
					write_timeout(16'hFFFF);
				end
				default: begin
					src_idle = 35;
					snk_idle = 35;
					write_timeout(16'($urandom_range(40, 7)));
				end
			endcase
			mark = beats_sent - ignored_beats;
			while (beats_sent - ignored_beats - mark < 70) begin
				pick = $urandom_range(99);
				cap = (cur_timeout < 3) ? int'(cur_timeout) : 3;
				fill_random();
				if (pick < 12)
					pkt_bytes[1] = 8'($urandom);
				seal_frame();
				if (pick >= 12 && pick < 22)
					pkt_bytes[LAST_IDX] ^= 8'(1 << $urandom_range(7));
				if (pick < 70) begin
					send_frame(cap);
				end else if (pick < 80) begin
					n = $urandom_range(4, 1);
					for (int k = 0; k < n; k++) begin
						if ($urandom_range(1))
							send_tick();
						else
							send_byte(8'($urandom));
					end
					ignored_beats += n;
				end else if (pick < 92) begin
					cut = $urandom_range(15);
					send_span(0, cut, cap);
					if (cur_timeout < 100)
						send_ticks(cur_timeout + 1);
				end else begin
					cut = $urandom_range(15);
					send_span(0, cut, cap);
					if (cur_timeout < 100)
						send_ticks(cur_timeout);
					send_span(cut + 1, FRAME_LEN - 1, 0);
				end
			end
		end

		drain();
		repeat (12) @(posedge clk);
		$display("sent %0d request beats under four idle mixes, %0d timeout settings",
			beats_sent, cfg_writes);
		$display("checked %0d decoded frames, %0d mismatches", frames_done, mismatch_total);
		if (mismatch_total == 0)
			$display("air_sensor_frame_decoder: match");
		else
			$display("air_sensor_frame_decoder: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/asfd_pkg.sv
hw/rtl/asfd_if.sv
hw/rtl/asfd_collector.sv
hw/rtl/asfd_decoder.sv
hw/rtl/air_sensor_frame_decoder.sv
test/asfd_decode_check.sv
test/tb_top.sv
